FILE: hw/rtl/tlf_pkg.sv
`default_nettype none
package tlf_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int FRAC_BITS   = 16;
	localparam int NUM_LETTERS = 26;
	localparam int IDX_W       = $clog2(NUM_LETTERS);
	localparam int FREQ_W      = 16;
	localparam int STEP_W      = $clog2(FRAC_BITS + 2);

	localparam logic [7:0] CH_NL    = 8'd10;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_HASH  = 8'd35;
	localparam logic [7:0] CH_AT    = 8'd64;
	localparam logic [7:0] CH_UA    = 8'd65;
	localparam logic [7:0] CH_UZ    = 8'd90;
	localparam logic [7:0] CH_A     = 8'd97;
	localparam logic [7:0] CH_Z     = 8'd122;
	localparam logic [7:0] CH_H     = 8'd104;
	localparam logic [7:0] CH_T     = 8'd116;
	localparam logic [7:0] CH_P     = 8'd112;
	localparam logic [7:0] CASE_OFS = 8'd32;

	localparam logic [IDX_W-1:0] IDX_H    = IDX_W'(CH_H - CH_A);
	localparam logic [IDX_W-1:0] IDX_T    = IDX_W'(CH_T - CH_A);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_LETTERS - 1);

	typedef enum logic [2:0] {
		MODE_NORMAL = 3'd0,
		MODE_SKIP   = 3'd1,
		MODE_H      = 3'd2,
		MODE_HT     = 3'd3,
		MODE_HTT    = 3'd4
	} filter_mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUTE,
		ST_BUMP_RD,
		ST_BUMP_WR,
		ST_DIV_RD,
		ST_DIV_LOAD,
		ST_DIV_STEP,
		ST_DIV_PUT
	} seq_state_t;

endpackage
`default_nettype wire

FILE: hw/rtl/tweet_letter_frequency_top.sv
`default_nettype none
// Letter frequency histogram over lines of text.
// Input stream s_*: one text byte per item in s_tdata; s_tuser flags start of
// text, which clears the counts and any pending skip or URL match first.
// Hashtags, mentions and http runs are dropped; letters are case folded.
// Output stream m_*: at every newline 26 items, letter a first, each with the
// letter's share of the line's counted symbols as a 0.16 fraction; m_tlast
// marks letter z.
// Each byte is accepted and then dispatched; each counter bump adds a read,
// a write and a re-dispatch of the count memory (up to four bumps after a
// failed URL match). A newline then runs the shared restoring divider, one
// quotient bit a cycle; for each letter it reads the count, loads, steps and
// puts the result. s_tready is low meanwhile.
// A result waits in the output register while m_tready is low; the divider
// finishes the next letter and then holds until the register frees.
// Reset clears mode, total and the per-entry valid bits of the count memory
// at once; no clearing pass is needed.
module tweet_letter_frequency_top (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	input  wire logic [7:0]                  s_tdata,  // [7:0] text_byte
	input  wire logic [0:0]                  s_tuser,  // [0] start_of_text
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	output logic [tlf_pkg::FREQ_W-1:0]       m_tdata,  // [15:0] frequency
	output logic [tlf_pkg::IDX_W-1:0]        m_tuser,  // [4:0] letter_index
	output logic                             m_tlast   // last_of_line
);
	import tlf_pkg::*;

	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	seq_state_t state_q, state_d;
	filter_mode_t mode_q;

	logic [COUNT_WIDTH-1:0] mem [NUM_LETTERS];
	logic [COUNT_WIDTH-1:0] rdata_q;
	logic [IDX_W-1:0]       rd_idx_q;
	logic [NUM_LETTERS-1:0] valid_q;
	logic [COUNT_WIDTH-1:0] total_q;

	logic             h_pend_q;
	logic [1:0]       t_cnt_q;
	logic             let_pend_q;
	logic [IDX_W-1:0] let_idx_q;
	logic             emit_q;

	logic [IDX_W-1:0]    k_q;
	logic [STEP_W-1:0]   step_q;
	logic [COUNT_WIDTH:0] rem_q;
	logic [FRAC_BITS:0]  quo_q;

	logic                out_vld_q;
	logic [FREQ_W-1:0]   out_freq_q;
	logic [IDX_W-1:0]    out_idx_q;

	// accept-time decode
	logic             accept;
	filter_mode_t     eff_mode, dec_mode;
	logic [7:0]       b, low_b;
	logic             dec_h, dec_let, dec_emit;
	logic [1:0]       dec_t;
	logic             n_skip, n_isl, n_ish;
	filter_mode_t     n_mode;

	assign accept = s_tvalid && s_tready;
	assign b      = s_tdata;

	always_comb begin
		eff_mode = s_tuser[0] ? MODE_NORMAL : mode_q;
		low_b    = (b >= CH_UA && b <= CH_UZ) ? b + CASE_OFS : b;
		n_skip   = (b == CH_HASH) || (b == CH_AT);
		n_isl    = (low_b >= CH_A) && (low_b <= CH_Z);
		n_ish    = (low_b == CH_H);
		n_mode   = n_skip ? MODE_SKIP : (n_ish ? MODE_H : MODE_NORMAL);
		dec_h    = 1'b0;
		dec_t    = 2'd0;
		dec_let  = n_isl && !n_ish;
		dec_emit = (b == CH_NL);
		dec_mode = n_mode;
		case (eff_mode)
			MODE_SKIP: begin
				dec_let  = 1'b0;
				dec_mode = (b == CH_SPACE || b == CH_NL) ? MODE_NORMAL : MODE_SKIP;
			end
			MODE_H: begin
				if (b == CH_T) begin
					dec_let  = 1'b0;
					dec_emit = 1'b0;
					dec_mode = MODE_HT;
				end else begin
					dec_h = 1'b1;
				end
			end
			MODE_HT: begin
				if (b == CH_T) begin
					dec_let  = 1'b0;
					dec_emit = 1'b0;
					dec_mode = MODE_HTT;
				end else begin
					dec_h = 1'b1;
					dec_t = 2'd1;
				end
			end
			MODE_HTT: begin
				if (b == CH_P) begin
					dec_let  = 1'b0;
					dec_emit = 1'b0;
					dec_mode = MODE_SKIP;
				end else begin
					dec_h = 1'b1;
					dec_t = 2'd2;
				end
			end
			default: begin
			end
		endcase
	end

	// bump order: pending h, then t's, then the current letter
	logic             any_pend;
	logic [IDX_W-1:0] bump_idx;
	assign any_pend = h_pend_q || (t_cnt_q != 2'd0) || let_pend_q;
	always_comb begin
		if (h_pend_q) begin
			bump_idx = IDX_H;
		end else if (t_cnt_q != 2'd0) begin
			bump_idx = IDX_T;
		end else begin
			bump_idx = let_idx_q;
		end
	end

	// shared divider step
	logic [COUNT_WIDTH:0] trial, total_x;
	logic                 ge;
	assign trial   = (step_q == '0) ? rem_q : {rem_q[COUNT_WIDTH-1:0], 1'b0};
	assign total_x = {1'b0, total_q};
	assign ge      = (trial >= total_x);

	logic [COUNT_WIDTH-1:0] cnt_in, cnt_inc, total_inc;
	assign cnt_in    = valid_q[rd_idx_q] ? rdata_q : '0;
	assign cnt_inc   = (cnt_in == CNT_MAX) ? cnt_in : cnt_in + 1'b1;
	assign total_inc = (total_q == CNT_MAX) ? total_q : total_q + 1'b1;

	logic out_free, last_k, last_step;
	assign out_free  = !out_vld_q || m_tready;
	assign last_k    = (k_q == IDX_LAST);
	assign last_step = (step_q == STEP_W'(FRAC_BITS));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (accept) state_d = ST_ROUTE;
			ST_ROUTE: begin
				if (any_pend)    state_d = ST_BUMP_RD;
				else if (emit_q) state_d = ST_DIV_RD;
				else             state_d = ST_IDLE;
			end
			ST_BUMP_RD:  state_d = ST_BUMP_WR;
			ST_BUMP_WR:  state_d = ST_ROUTE;
			ST_DIV_RD:   state_d = ST_DIV_LOAD;
			ST_DIV_LOAD: state_d = ST_DIV_STEP;
			ST_DIV_STEP: if (last_step) state_d = ST_DIV_PUT;
			ST_DIV_PUT: begin
				if (out_free) state_d = last_k ? ST_IDLE : ST_DIV_RD;
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	logic             mem_we, total_bump, div_start, put, clear_all;
	logic [IDX_W-1:0] raddr;
	always_comb begin
		s_tready   = (state_q == ST_IDLE);
		mem_we     = (state_q == ST_BUMP_WR);
		total_bump = mem_we || (state_q == ST_ROUTE && !any_pend && emit_q);
		div_start  = (state_q == ST_ROUTE && !any_pend && emit_q);
		put        = (state_q == ST_DIV_PUT) && out_free;
		clear_all  = put && last_k;
		raddr      = (state_q == ST_DIV_RD) ? k_q : bump_idx;
	end

	// count memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[rd_idx_q] <= cnt_inc;
		end
		rdata_q  <= mem[raddr];
		rd_idx_q <= raddr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			mode_q     <= MODE_NORMAL;
			valid_q    <= '0;
			total_q    <= '0;
			h_pend_q   <= 1'b0;
			t_cnt_q    <= 2'd0;
			let_pend_q <= 1'b0;
			emit_q     <= 1'b0;
			k_q        <= '0;
			step_q     <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				mode_q     <= dec_mode;
				h_pend_q   <= dec_h;
				t_cnt_q    <= dec_t;
				let_pend_q <= dec_let;
				emit_q     <= dec_emit;
				if (s_tuser[0]) begin
					valid_q <= '0;
					total_q <= '0;
				end
			end
			if (mem_we) begin
				valid_q[rd_idx_q] <= 1'b1;
				if (h_pend_q)              h_pend_q   <= 1'b0;
				else if (t_cnt_q != 2'd0)  t_cnt_q    <= t_cnt_q - 2'd1;
				else                       let_pend_q <= 1'b0;
			end
			if (total_bump) total_q <= total_inc;
			if (div_start) begin
				emit_q <= 1'b0;
				k_q    <= '0;
			end
			if (state_q == ST_DIV_LOAD) step_q <= '0;
			if (state_q == ST_DIV_STEP) step_q <= step_q + 1'b1;
			if (put) begin
				k_q <= k_q + 1'b1;
			end
			if (clear_all) begin
				valid_q <= '0;
				total_q <= '0;
			end
			if (put)           out_vld_q <= 1'b1;
			else if (m_tready) out_vld_q <= 1'b0;
		end
	end

	// divider and output payload
	always_ff @(posedge clk) begin
		if (accept) begin
			let_idx_q <= IDX_W'(low_b - CH_A);
		end
		if (state_q == ST_DIV_LOAD) begin
			rem_q <= {1'b0, cnt_in};
			quo_q <= '0;
		end
		if (state_q == ST_DIV_STEP) begin
			rem_q <= ge ? trial - total_x : trial;
			quo_q <= {quo_q[FRAC_BITS-1:0], ge};
		end
		if (put) begin
			out_idx_q  <= k_q;
			out_freq_q <= quo_q[FRAC_BITS] ? '1 : FREQ_W'(quo_q[FRAC_BITS-1:0]);
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_freq_q;
	assign m_tuser  = out_idx_q;
	assign m_tlast  = (out_idx_q == IDX_LAST);

`ifndef SYNTHESIS
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (!h_pend_q && t_cnt_q == 2'd0 && !let_pend_q && !emit_q))
		else $error("input taken with bump work still pending");
	a_tcnt: assert property (@(posedge clk) disable iff (!arst_n)
		t_cnt_q != 2'd3)
		else $error("more than two pending t bumps");
	a_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV_STEP && step_q != '0) |-> (rem_q < total_x))
		else $error("divider remainder not below divisor");
	a_put_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tuser)))
		else $error("stalled result overwritten");
`endif

endmodule
`default_nettype wire

FILE: tb/sv/tb_tweet_letter_frequency_top.sv
`timescale 1ns / 100ps

module tb_tweet_letter_frequency_top;
	import tlf_pkg::*;

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
	localparam logic [63:0] FRAC_MAX = (64'd1 << FRAC_BITS) - 64'd1;
	localparam int RANDOM_ITEMS = 350;
	localparam int LONG_HOLD = 2000;
	localparam int TAIL_CYCLES = 600;

	// one input item; chk marks a newline row whose line shares are typed in:
	// letter chk_idx gets chk_freq, all other letters zero
	typedef struct packed {
		logic [7:0]        data;
		logic              sot;
		logic              chk;
		logic [IDX_W-1:0]  chk_idx;
		logic [FREQ_W-1:0] chk_freq;
	} text_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]  idx;
		logic [FREQ_W-1:0] freq;
		logic              last;
	} share_t;

	typedef logic [FREQ_W-1:0] share_arr_t [NUM_LETTERS];

	localparam text_item_t DIR_TAB [25] = '{
		'{CH_NL,    1'b0, 1'b1, 5'd0,     16'h0000},  // empty line after reset
		'{"a",      1'b0, 1'b0, 5'd0,     16'h0000},
		'{CH_NL,    1'b0, 1'b1, 5'd0,     16'h8000},
		'{"Z",      1'b0, 1'b0, 5'd0,     16'h0000},  // upper case folds to z
		'{CH_NL,    1'b0, 1'b1, IDX_LAST, 16'h8000},
		'{CH_HASH,  1'b0, 1'b0, 5'd0,     16'h0000},  // hashtag skipped to space
		'{"x",      1'b0, 1'b0, 5'd0,     16'h0000},
		'{CH_SPACE, 1'b0, 1'b0, 5'd0,     16'h0000},
		'{"b",      1'b0, 1'b0, 5'd0,     16'h0000},
		'{CH_NL,    1'b0, 1'b1, 5'd1,     16'h8000},
		'{CH_AT,    1'b0, 1'b0, 5'd0,     16'h0000},  // newline ends a mention skip
		'{CH_NL,    1'b0, 1'b1, 5'd0,     16'h0000},
		'{"H",      1'b0, 1'b0, 5'd0,     16'h0000},  // full url match
		'{"t",      1'b0, 1'b0, 5'd0,     16'h0000},
		'{"t",      1'b0, 1'b0, 5'd0,     16'h0000},
		'{"p",      1'b0, 1'b0, 5'd0,     16'h0000},
		'{8'hFF,    1'b0, 1'b0, 5'd0,     16'h0000},
		'{CH_NL,    1'b0, 1'b1, 5'd0,     16'h0000},
		'{"h",      1'b0, 1'b0, 5'd0,     16'h0000},  // failed match after ht
		'{"t",      1'b0, 1'b0, 5'd0,     16'h0000},
		'{8'h00,    1'b0, 1'b0, 5'd0,     16'h0000},
		'{CH_NL,    1'b0, 1'b0, 5'd0,     16'h0000},
		'{"q",      1'b0, 1'b0, 5'd0,     16'h0000},
		'{"k",      1'b1, 1'b0, 5'd0,     16'h0000},  // start of text drops q
		'{CH_NL,    1'b0, 1'b1, 5'd10,    16'h8000}
	};

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [7:0]          s_tdata = '0;
	logic [0:0]          s_tuser = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [FREQ_W-1:0]   m_tdata;
	logic [IDX_W-1:0]    m_tuser;
	logic                m_tlast;

	logic [COUNT_WIDTH-1:0] letter_cnt [NUM_LETTERS];
	logic [COUNT_WIDTH-1:0] sym_total;
	filter_mode_t           fmode;

	text_item_t text_q[$];
	share_t     share_q[$];
	int         err_cnt = 0;
	int         hold_req = 0;

	always #5 clk = ~clk;

	tweet_letter_frequency_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// ---------------- line share predictor ----------------
	function automatic void clear_counts();
		for (int k = 0; k < NUM_LETTERS; k++)
			letter_cnt[k] = '0;
		sym_total = '0;
	endfunction

	function automatic void bump_total();
		if (sym_total != COUNT_MAX)
			sym_total = sym_total + 1'b1;
	endfunction

	function automatic void bump_letter(input logic [IDX_W-1:0] idx);
		if (letter_cnt[idx] != COUNT_MAX)
			letter_cnt[idx] = letter_cnt[idx] + 1'b1;
		bump_total();
	endfunction

	// newline counts itself, then every letter gets count / total
	function automatic void close_line(output share_arr_t sh);
		logic [63:0] q;
		bump_total();
		for (int k = 0; k < NUM_LETTERS; k++) begin
			q = '0;
			if (sym_total != '0) begin
				q = (64'(letter_cnt[k]) << FRAC_BITS) / 64'(sym_total);
				if (q > FRAC_MAX)
					q = FRAC_MAX;
			end
			sh[k] = q[FREQ_W-1:0];
		end
		clear_counts();
	endfunction

	function automatic bit plain_byte(input logic [7:0] b, output share_arr_t sh);
		fmode = MODE_NORMAL;
		if (b == CH_HASH || b == CH_AT) begin
			fmode = MODE_SKIP;
			return 1'b0;
		end
		if (b >= CH_UA && b <= CH_UZ)
			b = b + CASE_OFS;
		if (b >= CH_A && b <= CH_Z) begin
			if (b == CH_H)
				fmode = MODE_H;
			else
				bump_letter(IDX_W'(b - CH_A));
			return 1'b0;
		end
		if (b == CH_NL) begin
			close_line(sh);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// returns 1 when the byte closes a line; sh then holds the 26 shares
	function automatic bit advance_filter(input logic [7:0] b, input logic sot,
			output share_arr_t sh);
		if (sot) begin
			clear_counts();
			fmode = MODE_NORMAL;
		end
		case (fmode)
			MODE_SKIP: begin
				if (b == CH_SPACE) begin
					fmode = MODE_NORMAL;
					return 1'b0;
				end
				if (b == CH_NL) begin
					fmode = MODE_NORMAL;
					close_line(sh);
					return 1'b1;
				end
				return 1'b0;
			end
			MODE_H: begin
				if (b == CH_T) begin
					fmode = MODE_HT;
					return 1'b0;
				end
				bump_letter(IDX_H);
				return plain_byte(b, sh);
			end
			MODE_HT: begin
				if (b == CH_T) begin
					fmode = MODE_HTT;
					return 1'b0;
				end
				bump_letter(IDX_H);
				bump_letter(IDX_T);
				return plain_byte(b, sh);
			end
			MODE_HTT: begin
				if (b == CH_P) begin
					fmode = MODE_SKIP;
					return 1'b0;
				end
				bump_letter(IDX_H);
				bump_letter(IDX_T);
				bump_letter(IDX_T);
				return plain_byte(b, sh);
			end
			default: return plain_byte(b, sh);
		endcase
	endfunction

	// ---------------- stimulus ----------------
	task automatic push_byte(input logic [7:0] b);
		text_item_t it;
		it = '0;
		it.data = b;
		it.sot = ($urandom_range(0, 99) < 3);
		text_q.push_back(it);
	endtask

	task automatic push_word(input int max_len);
		int n;
		logic [7:0] c;
		n = $urandom_range(1, max_len);
		repeat (n) begin
			c = CH_A + 8'($urandom_range(0, NUM_LETTERS - 1));
			if ($urandom_range(0, 99) < 30)
				c = c - CASE_OFS;
			push_byte(c);
		end
	endtask

	task automatic send_text(input text_item_t it);
		int gap;
		share_arr_t sh;
		share_t exp;
		gap = gap_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= it.data;
		s_tuser <= it.sot;
		do @(posedge clk); while (!s_tready);
		if (advance_filter(it.data, it.sot, sh)) begin
			for (int k = 0; k < NUM_LETTERS; k++) begin
				exp.idx = IDX_W'(k);
				if (it.chk)
					exp.freq = (IDX_W'(k) == it.chk_idx) ? it.chk_freq : '0;
				else
					exp.freq = sh[k];
				exp.last = (IDX_W'(k) == IDX_LAST);
				share_q.push_back(exp);
			end
		end
	endtask

	task automatic note_error(input string msg);
		err_cnt++;
		if (err_cnt <= 10)
			$display("ERROR: %s", msg);
	endtask

	initial begin
		int n_dir;
		int tokens;
		int pick;
		int r;
		clear_counts();
		fmode = MODE_NORMAL;
		foreach (DIR_TAB[i])
			text_q.push_back(DIR_TAB[i]);
		n_dir = text_q.size();
		// mostly words with hashtags, mentions, urls and partial urls mixed in
		while (text_q.size() < n_dir + RANDOM_ITEMS) begin
			tokens = $urandom_range(1, 6);
			repeat (tokens) begin
				pick = $urandom_range(0, 99);
				if (pick < 35) begin
					push_word(6);
				end else if (pick < 45) begin
					push_byte(($urandom_range(0, 1) != 0) ? CH_HASH : CH_AT);
					push_word(5);
					if ($urandom_range(0, 3) == 0)
						push_byte(8'($urandom_range(0, 255)));
				end else if (pick < 55) begin
					push_byte(($urandom_range(0, 1) != 0) ? CH_H : CH_H - CASE_OFS);
					push_byte(CH_T);
					push_byte(CH_T);
					push_byte(CH_P);
					push_word(6);
				end else if (pick < 70) begin
					push_byte(($urandom_range(0, 1) != 0) ? CH_H : CH_H - CASE_OFS);
					if ($urandom_range(0, 1) != 0) begin
						push_byte(CH_T);
						if ($urandom_range(0, 1) != 0)
							push_byte(CH_T);
					end
					r = $urandom_range(0, 7);
					case (r)
						0: push_byte(CH_NL);
						1: push_byte(CH_HASH);
						2: push_byte(CH_H);
						3: push_byte(CH_SPACE);
						4: push_byte(CH_T - CASE_OFS);
						5: push_byte(CH_P);
						default: push_byte(8'($urandom_range(0, 255)));
					endcase
				end else if (pick < 85) begin
					push_byte(8'($urandom_range(0, 255)));
				end else begin
					push_byte(CH_SPACE);
				end
				if ($urandom_range(0, 99) < 70)
					push_byte(CH_SPACE);
			end
			if ($urandom_range(0, 9) != 0)
				push_byte(CH_NL);
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < text_q.size(); i++) begin
			if (i == n_dir)
				hold_req <= hold_req + 1;
			if (i == n_dir + RANDOM_ITEMS / 2) begin
				// let every pending line drain before going on
				s_tvalid <= 1'b0;
				do @(posedge clk); while (share_q.size() != 0);
			end
			send_text(text_q[i]);
		end
		s_tvalid <= 1'b0;
		do @(posedge clk); while (share_q.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (share_q.size() != 0)
			note_error($sformatf("%0d results never arrived", share_q.size()));
		if (err_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// ---------------- result side ----------------
	initial begin
		int hold_left;
		int left;
		int hold_seen;
		bit rdy;
		share_t exp;
		hold_left = 0;
		left = 0;
		hold_seen = 0;
		rdy = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (share_q.size() == 0) begin
					note_error($sformatf("unexpected result letter %0d freq %h last %0b",
						m_tuser, m_tdata, m_tlast));
				end else begin
					exp = share_q.pop_front();
					if (m_tuser !== exp.idx || m_tdata !== exp.freq || m_tlast !== exp.last)
						note_error($sformatf(
							"exp letter %0d freq %h last %0b, got letter %0d freq %h last %0b",
							exp.idx, exp.freq, exp.last, m_tuser, m_tdata, m_tlast));
				end
			end
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				if (left == 0) begin
					rdy = !rdy;
					if (rdy) begin
						left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
							: $urandom_range(1, 24);
					end else begin
						left = gap_len();
						if (left == 0)
							left = 1;
					end
				end
				left--;
				m_tready <= rdy;
			end
		end
	end

	initial begin
		#(40_000_000);
		$display("Regression FAIL");
		$finish;
	end

endmodule
